// ----- src/cmlt_pkg.sv -----
// Shared types and constants for the channel map lookup table.
package cmlt_pkg;

  localparam int IDX_W = 8;
  localparam int CFG_W = 9;
  localparam int ADDR_W = 16;
  localparam int TYPE_W = 2;
  localparam int REACH = 256;

  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;
  localparam logic [ADDR_W-1:0] ADDR_RESET = 16'hFFFF;

  // Register types
  localparam logic [TYPE_W-1:0] REG_COIL = 2'd0;
  localparam logic [TYPE_W-1:0] REG_DISCRETE = 2'd1;
  localparam logic [TYPE_W-1:0] REG_INPUT = 2'd2;
  localparam logic [TYPE_W-1:0] REG_HOLDING = 2'd3;

  // Operation codes
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ = 2'd1;
  localparam logic [1:0] FUNC_FIND_GROUP = 2'd2;
  localparam logic [1:0] FUNC_FIND_REG = 2'd3;

  typedef struct packed {
    logic              active;
    logic [ADDR_W-1:0] group_key;
    logic [TYPE_W-1:0] reg_kind;
    logic [ADDR_W-1:0] reg_num;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    active:    1'b0,
    group_key: ADDR_RESET,
    reg_kind:  REG_HOLDING,
    reg_num:   ADDR_RESET
  };

  typedef struct packed {
    logic [1:0]        func;
    logic [IDX_W-1:0]  entry_index;
    logic              entry_active;
    logic [ADDR_W-1:0] entry_group_addr;
    logic [TYPE_W-1:0] entry_reg_type;
    logic [ADDR_W-1:0] entry_reg_addr;
  } cmd_t;

  typedef struct packed {
    logic              ok;
    logic [IDX_W-1:0]  slot;
    logic              stored_active;
    logic [ADDR_W-1:0] stored_group_addr;
    logic [TYPE_W-1:0] stored_reg_type;
    logic [ADDR_W-1:0] stored_reg_addr;
  } rsp_t;

  // Ring control from the sequencer: rotate strobe and data fed to the tail cell
  typedef struct packed {
    logic   shift;
    entry_t data;
  } ring_t;

endpackage

// ----- src/channel_map_lookup_table.sv -----
// A result strobes with done once the scan is through; start is taken only while idle, so a command waits for the last.
// Every command rotates the ring of entry cells through one full revolution, one cell per cycle.
// Writes land as the addressed entry wraps past the head; finds keep the lowest active match.
// The result shows for one cycle with done; the receiver cannot stall.
// Reset: entries go to factory defaults at once, entries_in_use to 256, ring aligned at index 0.
module channel_map_lookup_table
  import cmlt_pkg::*;
#(
  parameter int ENTRIES = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  cmd_t             cmd,
  output logic             done,
  output rsp_t             rsp,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data
);

  entry_t cell_q [ENTRIES];
  ring_t  ring;

  cmlt_seq #(
    .ENTRIES (ENTRIES)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd      (cmd),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .head     (cell_q[0]),
    .ring     (ring),
    .busy     (busy),
    .done     (done),
    .rsp      (rsp)
  );

  // Ring of cells: each hands its entry toward the head; the tail takes the sequencer feed
  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    if (k == ENTRIES - 1) begin : g_tail
      cmlt_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (ring.shift),
        .d     (ring.data),
        .q     (cell_q[k])
      );
    end else begin : g_body
      cmlt_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (ring.shift),
        .d     (cell_q[k+1]),
        .q     (cell_q[k])
      );
    end
  end

endmodule

// ----- src/cmlt_cell.sv -----
// One table cell: holds a single entry and passes it to its neighbor on a rotate.
module cmlt_cell
  import cmlt_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   shift,
  input  entry_t d,
  output entry_t q
);

  entry_t held;

  // Factory default at reset, take the neighbor's entry on each rotate
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= ENTRY_RESET;
    end else if (shift) begin
      held <= d;
    end
  end

  assign q = held;

endmodule

// ----- src/cmlt_seq.sv -----
// Sequencer: walks one full ring revolution per command and builds the result.
module cmlt_seq
  import cmlt_pkg::*;
#(
  parameter int ENTRIES = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  cmd_t             cmd,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  input  entry_t           head,
  output ring_t            ring,
  output logic             busy,
  output logic             done,
  output rsp_t             rsp
);

  localparam int SW = $clog2(ENTRIES);
  localparam int CMPW = (SW > CFG_W) ? SW : CFG_W;
  localparam logic [CFG_W-1:0] LIM_CAP =
    CFG_W'((ENTRIES < REACH) ? ENTRIES : REACH);
  localparam logic [SW-1:0] LAST_STEP = SW'(ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CFG_W-1:0] entries_in_use;
  logic [SW-1:0]    step;
  cmd_t             op;
  logic             found;
  logic             found_next;
  rsp_t             rsp_q;
  rsp_t             rsp_next;
  rsp_t             rsp_init;
  logic             done_q;

  logic [CFG_W-1:0] lim;
  logic [CMPW-1:0]  step_c;
  logic             in_lim;
  logic             at_index;
  logic             is_find;
  logic             key_match;
  logic             last;
  entry_t           wr_entry;
  entry_t           tail_in;

  function automatic logic is_find_code(input logic [1:0] f);
    return (f == FUNC_FIND_GROUP) || (f == FUNC_FIND_REG);
  endfunction

  assign lim = (entries_in_use < LIM_CAP) ? entries_in_use : LIM_CAP;
  assign step_c = CMPW'(step);
  assign in_lim = step_c < CMPW'(lim);
  assign at_index = in_lim && (step_c == CMPW'(op.entry_index));
  assign is_find = (op.func == FUNC_FIND_GROUP) || (op.func == FUNC_FIND_REG);
  assign last = (step == LAST_STEP);

  assign wr_entry = '{
    active:    op.entry_active,
    group_key: op.entry_group_addr,
    reg_kind:  op.entry_reg_type,
    reg_num:   op.entry_reg_addr
  };

  // Key compare on the entry sitting in the head cell
  always_comb begin
    if (op.func == FUNC_FIND_GROUP) begin
      key_match = (head.group_key == op.entry_group_addr);
    end else begin
      key_match = (head.reg_kind == op.entry_reg_type) &&
                  (head.reg_num == op.entry_reg_addr);
    end
  end

  // Result build-up and write substitution as the head entry wraps to the tail
  always_comb begin
    rsp_next = rsp_q;
    found_next = found;
    tail_in = head;
    case (op.func)
      FUNC_WRITE: begin
        if (at_index) begin
          tail_in = wr_entry;
          rsp_next = '{1'b1, op.entry_index, wr_entry.active, wr_entry.group_key,
                       wr_entry.reg_kind, wr_entry.reg_num};
        end
      end
      FUNC_READ: begin
        if (at_index) begin
          rsp_next = '{1'b1, op.entry_index, head.active, head.group_key,
                       head.reg_kind, head.reg_num};
        end
      end
      default: begin
        if (is_find && !found && in_lim && head.active && key_match) begin
          found_next = 1'b1;
          rsp_next = '{1'b1, step_c[IDX_W-1:0], head.active, head.group_key,
                       head.reg_kind, head.reg_num};
        end
      end
    endcase
  end

  // Starting result: failed search, or echoed index for write and read
  always_comb begin
    rsp_init = '0;
    rsp_init.slot = is_find_code(cmd.func) ? '0 : cmd.entry_index;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
      done_q <= 1'b0;
      found <= 1'b0;
      entries_in_use <= CFG_RESET;
    end else begin
      state <= state_next;
      done_q <= (state == ST_SCAN) && last;
      if (cfg_we) begin
        entries_in_use <= cfg_data;
      end
      if (state == ST_IDLE) begin
        step <= '0;
        found <= 1'b0;
      end else begin
        step <= last ? '0 : step + 1'b1;
        found <= found_next;
      end
    end
  end

  // Command latch and result register
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      op <= cmd;
      rsp_q <= rsp_init;
    end else if (state == ST_SCAN) begin
      rsp_q <= rsp_next;
    end
  end

  assign ring = '{shift: (state == ST_SCAN), data: tail_in};
  assign busy = (state == ST_SCAN);
  assign done = done_q;
  assign rsp = rsp_q;

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the channel map lookup table.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cmlt_pkg::*;

  localparam int ENTRIES = 256;
  localparam int RANDOM_ITEMS = 1800;
  localparam int PHASES = 8;

  // Table sizes visited by the random part; the last one is drawn at random
  localparam int PHASE_SIZE [PHASES] = '{256, 1, 2, 17, 64, 255, 400, 0};

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  cmd_t             cmd = '0;
  logic             done;
  rsp_t             rsp;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  // Shadow copy of the table and of the size register
  entry_t shadow_entries [ENTRIES];
  int     shadow_limit;

  rsp_t   pending_rsp [$];
  int     fail_count = 0;
  int     results_seen = 0;
  int     sizes_visited = 0;
  int     func_count [4] = '{0, 0, 0, 0};

  channel_map_lookup_table #(
    .ENTRIES(ENTRIES)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .done    (done),
    .rsp     (rsp),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit
  initial begin
    #200ms;
    $display("TB_ERROR");
    $finish;
  end

  // Response for one stored entry
  function automatic rsp_t entry_response(int idx);
    rsp_t r;
    r.ok                = 1'b1;
    r.slot              = idx[IDX_W-1:0];
    r.stored_active     = shadow_entries[idx].active;
    r.stored_group_addr = shadow_entries[idx].group_key;
    r.stored_reg_type   = shadow_entries[idx].reg_kind;
    r.stored_reg_addr   = shadow_entries[idx].reg_num;
    return r;
  endfunction

  // Expected response of one command; applies writes to the shadow table
  function automatic rsp_t compute_response(cmd_t c);
    rsp_t r;
    bit   hit;
    r = '0;
    hit = 1'b0;
    if (c.func == FUNC_WRITE || c.func == FUNC_READ) begin
      r.slot = c.entry_index;
      if (int'(c.entry_index) < shadow_limit) begin
        if (c.func == FUNC_WRITE) begin
          shadow_entries[c.entry_index] = '{
            active:    c.entry_active,
            group_key: c.entry_group_addr,
            reg_kind:  c.entry_reg_type,
            reg_num:   c.entry_reg_addr
          };
        end
        r = entry_response(c.entry_index);
      end
    end else begin
      // Lowest active match wins
      for (int i = 0; i < shadow_limit && !hit; i++) begin
        if (shadow_entries[i].active) begin
          if (c.func == FUNC_FIND_GROUP) begin
            hit = (shadow_entries[i].group_key == c.entry_group_addr);
          end else begin
            hit = (shadow_entries[i].reg_kind == c.entry_reg_type) &&
                  (shadow_entries[i].reg_num == c.entry_reg_addr);
          end
          if (hit) begin
            r = entry_response(i);
          end
        end
      end
    end
    return r;
  endfunction

  function automatic cmd_t make_cmd(logic [1:0] func, int idx, logic act,
                                    logic [ADDR_W-1:0] group, logic [TYPE_W-1:0] rtype,
                                    logic [ADDR_W-1:0] raddr);
    cmd_t c;
    c.func             = func;
    c.entry_index      = idx[IDX_W-1:0];
    c.entry_active     = act;
    c.entry_group_addr = group;
    c.entry_reg_type   = rtype;
    c.entry_reg_addr   = raddr;
    return c;
  endfunction

  // Every field fully random
  function automatic cmd_t noise_cmd();
    return make_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 255),
                    1'($urandom_range(0, 1)), 16'($urandom),
                    2'($urandom_range(0, 3)), 16'($urandom));
  endfunction

  // Keys mostly from a small pool so that searches hit and collide
  function automatic logic [ADDR_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h1234;
      3: return 16'h0A01;
      4: return 16'h8000;
      5: return 16'h7FFF;
      6: return 16'h0001;
      7: return 16'h5555;
      default: return 16'($urandom);
    endcase
  endfunction

  // Idle cycles after a transfer: mostly none, some short, some near the end of the scan, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 75) return $urandom_range(1, 8);
    if (r < 92) return $urandom_range(ENTRIES - 8, ENTRIES + 8);
    return $urandom_range(ENTRIES, 3 * ENTRIES);
  endfunction

  // Mostly well-formed commands aimed at the live part of the table
  function automatic cmd_t random_cmd();
    int         r;
    int         idx;
    logic [1:0] func;
    r = $urandom_range(0, 99);
    if (r < 8) return noise_cmd();
    r = $urandom_range(0, 99);
    if (r < 35) func = FUNC_WRITE;
    else if (r < 55) func = FUNC_READ;
    else if (r < 77) func = FUNC_FIND_GROUP;
    else func = FUNC_FIND_REG;
    if (shadow_limit > 0 && $urandom_range(0, 99) < 85) begin
      idx = $urandom_range(0, shadow_limit - 1);
    end else begin
      idx = $urandom_range(0, 255);
    end
    return make_cmd(func, idx, ($urandom_range(0, 99) < 85), pick_key(),
                    2'($urandom_range(0, 3)), pick_key());
  endfunction

  // One command transfer, then the requested idle time
  task automatic send_cmd(cmd_t c, int gap);
    @(negedge clk);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    pending_rsp.push_back(compute_response(c));
    func_count[c.func]++;
    @(negedge clk);
    start <= 1'b0;
    cmd   <= noise_cmd();
    repeat (gap) @(posedge clk);
  endtask

  // Hold off until every expected result is back and the block is idle
  task automatic wait_drained();
    while (pending_rsp.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_entries_in_use(logic [CFG_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    cfg_data <= CFG_W'($urandom);
    shadow_limit = (int'(value) > ENTRIES) ? ENTRIES : int'(value);
    sizes_visited++;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    rsp_t want;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        $error("result strobe with no command outstanding");
        fail_count++;
      end else begin
        want = pending_rsp.pop_front();
        check_field("ok", want.ok, rsp.ok);
        check_field("slot", want.slot, rsp.slot);
        check_field("stored_active", want.stored_active, rsp.stored_active);
        check_field("stored_group_addr", want.stored_group_addr, rsp.stored_group_addr);
        check_field("stored_reg_type", want.stored_reg_type, rsp.stored_reg_type);
        check_field("stored_reg_addr", want.stored_reg_addr, rsp.stored_reg_addr);
        results_seen++;
      end
    end
  end

  // Factory defaults are visible and inactive entries never match
  task automatic test_reset_defaults();
    send_cmd(make_cmd(FUNC_READ, 0, 1'b1, 16'h0000, REG_COIL, 16'h0000), pick_gap());
    send_cmd(make_cmd(FUNC_READ, 255, 1'b0, 16'hFFFF, REG_HOLDING, 16'hFFFF), pick_gap());
    send_cmd(make_cmd(FUNC_FIND_GROUP, 0, 1'b1, ADDR_RESET, REG_COIL, 16'h0000), 0);
    send_cmd(make_cmd(FUNC_FIND_REG, 0, 1'b1, 16'h0000, REG_HOLDING, ADDR_RESET), 0);
  endtask

  // All four operations, field extremes, lowest match and skipped inactive entries
  task automatic test_operations();
    send_cmd(make_cmd(FUNC_WRITE, 0, 1'b1, 16'h0000, REG_COIL, 16'h0000), 0);
    send_cmd(make_cmd(FUNC_WRITE, 255, 1'b1, 16'hFFFF, REG_HOLDING, 16'hFFFF), 0);
    send_cmd(make_cmd(FUNC_WRITE, 7, 1'b1, 16'h1234, REG_DISCRETE, 16'h8000), 0);
    send_cmd(make_cmd(FUNC_WRITE, 3, 1'b1, 16'h1234, REG_INPUT, 16'h8000), pick_gap());
    send_cmd(make_cmd(FUNC_WRITE, 2, 1'b0, 16'h1234, REG_DISCRETE, 16'h8000), 0);
    send_cmd(make_cmd(FUNC_FIND_GROUP, 200, 1'b0, 16'h1234, REG_HOLDING, 16'hFFFF), 0);
    send_cmd(make_cmd(FUNC_FIND_REG, 9, 1'b1, 16'hFFFF, REG_DISCRETE, 16'h8000), 0);
    send_cmd(make_cmd(FUNC_FIND_REG, 0, 1'b1, 16'h1234, REG_INPUT, 16'h8001), 0);
    send_cmd(make_cmd(FUNC_FIND_GROUP, 0, 1'b1, 16'hFFFF, REG_COIL, 16'h0000), 0);
    send_cmd(make_cmd(FUNC_READ, 7, 1'b0, 16'hFFFF, REG_HOLDING, 16'hFFFF), 0);
    send_cmd(make_cmd(FUNC_FIND_GROUP, 0, 1'b1, 16'hABCD, REG_COIL, 16'h0000), 0);
  endtask

  // Index range and search reach follow entries_in_use, including zero and above 256
  task automatic test_entry_limits();
    set_entries_in_use(9'd1);
    send_cmd(make_cmd(FUNC_READ, 0, 1'b0, 16'h0000, REG_COIL, 16'h0000), 0);
    send_cmd(make_cmd(FUNC_WRITE, 1, 1'b1, 16'hBEEF, REG_INPUT, 16'h4321), 0);
    send_cmd(make_cmd(FUNC_FIND_GROUP, 0, 1'b0, 16'h1234, REG_COIL, 16'h0000), 0);
    send_cmd(make_cmd(FUNC_FIND_REG, 0, 1'b0, 16'h0000, REG_COIL, 16'h0000), 0);
    set_entries_in_use(9'd0);
    send_cmd(make_cmd(FUNC_READ, 0, 1'b0, 16'h0000, REG_COIL, 16'h0000), 0);
    send_cmd(make_cmd(FUNC_WRITE, 0, 1'b1, 16'h2222, REG_INPUT, 16'h3333), 0);
    send_cmd(make_cmd(FUNC_FIND_GROUP, 0, 1'b0, 16'h0000, REG_COIL, 16'h0000), 0);
    set_entries_in_use(9'd255);
    send_cmd(make_cmd(FUNC_FIND_GROUP, 0, 1'b0, 16'hFFFF, REG_COIL, 16'h0000), 0);
    send_cmd(make_cmd(FUNC_READ, 255, 1'b0, 16'h0000, REG_COIL, 16'h0000), 0);
    set_entries_in_use(9'd511);
    send_cmd(make_cmd(FUNC_READ, 1, 1'b0, 16'h0000, REG_COIL, 16'h0000), 0);
    send_cmd(make_cmd(FUNC_FIND_GROUP, 0, 1'b0, 16'hFFFF, REG_COIL, 16'h0000), 0);
    set_entries_in_use(CFG_RESET);
  endtask

  // Random traffic over several table sizes, with one full drain mid-phase
  task automatic test_random_traffic();
    int per_phase;
    int size;
    per_phase = RANDOM_ITEMS / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      size = (PHASE_SIZE[p] == 0) ? $urandom_range(1, 256) : PHASE_SIZE[p];
      set_entries_in_use(size[CFG_W-1:0]);
      for (int n = 0; n < per_phase; n++) begin
        if (p == 3 && n == per_phase / 2) begin
          wait_drained();
        end
        // Stretches of back-to-back transfers
        send_cmd(random_cmd(), (n % 64 < 16) ? 0 : pick_gap());
      end
    end
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_entries[i] = ENTRY_RESET;
    end
    shadow_limit = int'(CFG_RESET);

    // Synchronous reset, released on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_operations();
    test_entry_limits();
    test_random_traffic();

    wait_drained();
    repeat (ENTRIES + 8) @(posedge clk);

    $display("Checked %0d results over %0d table size settings", results_seen, sizes_visited);
    $display("Writes %0d, reads %0d, group finds %0d, register finds %0d",
             func_count[FUNC_WRITE], func_count[FUNC_READ],
             func_count[FUNC_FIND_GROUP], func_count[FUNC_FIND_REG]);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/cmlt_pkg.sv
src/cmlt_cell.sv
src/cmlt_seq.sv
src/channel_map_lookup_table.sv
verif/testbench.sv
